@@ sv/diff_drive_odometry_defines.svh @@
// ----------------------------------------------------------------------------
// diff_drive_odometry_defines
// assertion macros shared by the odometry rtl
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg
// types and constants of the differential drive odometry block
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_TICK = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_WHEEL_BASE = 8'd1;

	localparam logic [31:0] MPT_RESET = 32'd16777;
	localparam logic [31:0] IWB_RESET = 32'd83886080;

	// round(2^32 / (2 pi))
	localparam logic [31:0] TURN_PER_RADIAN = 32'd683565276;

	localparam int MUL_W = 33;
	localparam int PROD_W = 66;
	localparam int CENTRE_W = 56;
	localparam int ACC_W = 88;
	localparam int INC_W = 58;
	localparam int POS_W = 59;
	localparam int CXY_W = 34;
	localparam int Z_W = 33;
	localparam int CNT_W = 6;

	localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CXY_W-1:0] TRIG_MAX = 34'sd1073741824;
	localparam logic signed [CXY_W-1:0] TRIG_MIN = -34'sd1073741824;

	localparam logic signed [POS_W-1:0] POS_MAX = 59'sd2147483647;
	localparam logic signed [POS_W-1:0] POS_MIN = -59'sd2147483648;

	// arctangent of 2^-k in binary angle units
	localparam logic [31:0] ATAN_TABLE [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	typedef enum logic [3:0] {
		OP_CENTRE,
		OP_RATE,
		OP_STEP_HI,
		OP_STEP_LO,
		OP_TURN_HI,
		OP_TURN_LO,
		OP_X_HI,
		OP_X_LO,
		OP_Y_HI,
		OP_Y_LO
	} op_t;

endpackage

@@ sv/diff_drive_odometry.sv @@
// ----------------------------------------------------------------------------
// diff_drive_odometry
// dead-reckoning pose update of a differential drive from wheel tick deltas
// ----------------------------------------------------------------------------
// Each request carries the left and right tick deltas of one sample and
// returns the new pose (x, y in Q16.16 metres, saturating; heading as a
// wrapping 32-bit binary angle). The block takes one request at a time and
// accepts the next only after the last one is done. The work is the
// iterative CORDIC, one micro-rotation a cycle, followed by the four
// position products; all ten products go one at a time through a single
// 33 x 33 signed multiplier, the first six of them alongside the rotation.
// A finished pose waits in the output register while the next request is
// worked on.
`include "diff_drive_odometry_defines.svh"

module diff_drive_odometry #(
	parameter int TICK_WIDTH = 16,
	parameter int CORDIC_STEPS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// left_ticks, right_ticks
	input  logic [((2*TICK_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// pose_x, pose_y, pose_heading
	output logic [95:0]                     m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data
);

	import ddo_pkg::*;

	state_t                      state_q, state_d;
	op_t                         op_q, op_d;
	logic                        mph_q, mph_d;
	logic [CNT_W-1:0]            cnt_q;
	logic                        out_valid_q;

	logic [31:0]                 mpt_q, iwb_q;
	logic signed [31:0]          x_q, y_q;
	logic [31:0]                 heading_q;

	logic signed [TICK_WIDTH:0]  tsum_q, tdiff_q;
	logic signed [CENTRE_W-1:0]  centre_q;
	logic [63:0]                 rate_q, step_q;
	logic [31:0]                 turn_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic [1:0]                  quad_q;
	logic signed [Z_W-1:0]       z_q;
	logic signed [CXY_W-1:0]     cx_q, cy_q;
	logic signed [31:0]          out_x_q, out_y_q;
	logic [31:0]                 out_h_q;

	logic                        start, cordic_done, cordic_step, mul_fire, mul_use, finish;
	logic signed [TICK_WIDTH-1:0] left_ticks, right_ticks;
	logic [31:0]                 fold_sum, fold_z;
	logic [4:0]                  rot_k;
	logic signed [CXY_W-1:0]     sh_x, sh_y, cl_x, cl_y;
	logic signed [Z_W-1:0]       rot_atan;
	logic signed [31:0]          cos_v, sin_v, trig_v, pos_old;
	logic signed [MUL_W-1:0]     mul_a, mul_b;
	logic signed [PROD_W-1:0]    mul_p;
	logic signed [ACC_W-1:0]     acc_sum;
	logic signed [INC_W-1:0]     pos_inc;
	logic signed [POS_W-1:0]     pos_sum;
	logic signed [31:0]          pos_sat;

	assign left_ticks = s_axis_tdata[TICK_WIDTH-1:0];
	assign right_ticks = s_axis_tdata[2*TICK_WIDTH-1:TICK_WIDTH];

	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {out_h_q, out_y_q, out_x_q};

	// sequencer
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		mph_d = mph_q;
		s_axis_tready = 1'b0;
		start = 1'b0;
		mul_fire = 1'b0;
		mul_use = 1'b0;
		finish = 1'b0;
		cordic_done = (cnt_q == CNT_W'(CORDIC_STEPS));
		cordic_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					start = 1'b1;
					op_d = OP_CENTRE;
					mph_d = 1'b0;
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				cordic_step = !cordic_done;
				if (!mph_q) begin
					if (op_q != OP_X_HI || cordic_done) begin
						mul_fire = 1'b1;
						mph_d = 1'b1;
					end
				end else if (op_q != OP_Y_LO || !out_valid_q || m_axis_tready) begin
					mul_use = 1'b1;
					mph_d = 1'b0;
					unique case (op_q)
						OP_CENTRE:  op_d = OP_RATE;
						OP_RATE:    op_d = OP_STEP_HI;
						OP_STEP_HI: op_d = OP_STEP_LO;
						OP_STEP_LO: op_d = OP_TURN_HI;
						OP_TURN_HI: op_d = OP_TURN_LO;
						OP_TURN_LO: op_d = OP_X_HI;
						OP_X_HI:    op_d = OP_X_LO;
						OP_X_LO:    op_d = OP_Y_HI;
						OP_Y_HI:    op_d = OP_Y_LO;
						default: begin
							op_d = OP_CENTRE;
							finish = 1'b1;
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// angle fold and micro-rotation
	assign fold_sum = heading_q + 32'h4000_0000;
	assign fold_z = heading_q - {fold_sum[31:30], 30'd0};
	assign rot_k = cnt_q[4:0];
	assign sh_x = cx_q >>> rot_k;
	assign sh_y = cy_q >>> rot_k;
	assign rot_atan = $signed({1'b0, ATAN_TABLE[rot_k]});

	always_comb begin
		if (cx_q > TRIG_MAX) begin
			cl_x = TRIG_MAX;
		end else if (cx_q < TRIG_MIN) begin
			cl_x = TRIG_MIN;
		end else begin
			cl_x = cx_q;
		end
		if (cy_q > TRIG_MAX) begin
			cl_y = TRIG_MAX;
		end else if (cy_q < TRIG_MIN) begin
			cl_y = TRIG_MIN;
		end else begin
			cl_y = cy_q;
		end
		unique case (quad_q)
			2'd0: begin
				cos_v = 32'(cl_x);
				sin_v = 32'(cl_y);
			end
			2'd1: begin
				cos_v = -32'(cl_y);
				sin_v = 32'(cl_x);
			end
			2'd2: begin
				cos_v = -32'(cl_x);
				sin_v = -32'(cl_y);
			end
			default: begin
				cos_v = 32'(cl_y);
				sin_v = -32'(cl_x);
			end
		endcase
	end

	// shared multiplier operands
	assign trig_v = (op_q == OP_X_HI || op_q == OP_X_LO) ? cos_v : sin_v;

	always_comb begin
		unique case (op_q)
			OP_CENTRE: begin
				mul_a = MUL_W'(tsum_q);
				mul_b = $signed({1'b0, mpt_q});
			end
			OP_RATE: begin
				mul_a = $signed({1'b0, mpt_q});
				mul_b = $signed({1'b0, iwb_q});
			end
			OP_STEP_HI: begin
				mul_a = $signed({1'b0, rate_q[63:32]});
				mul_b = $signed({1'b0, TURN_PER_RADIAN});
			end
			OP_STEP_LO: begin
				mul_a = $signed({1'b0, rate_q[31:0]});
				mul_b = $signed({1'b0, TURN_PER_RADIAN});
			end
			OP_TURN_HI: begin
				mul_a = MUL_W'(tdiff_q);
				mul_b = $signed({1'b0, step_q[63:32]});
			end
			OP_TURN_LO: begin
				mul_a = MUL_W'(tdiff_q);
				mul_b = $signed({1'b0, step_q[31:0]});
			end
			OP_X_HI, OP_Y_HI: begin
				mul_a = MUL_W'($signed(centre_q[CENTRE_W-1:32]));
				mul_b = MUL_W'(trig_v);
			end
			OP_X_LO, OP_Y_LO: begin
				mul_a = $signed({1'b0, centre_q[31:0]});
				mul_b = MUL_W'(trig_v);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// position accumulate and saturate
	assign acc_sum = acc_q + ACC_W'(prod_q);
	assign pos_inc = acc_sum[ACC_W-1:30];
	assign pos_old = (op_q == OP_X_LO) ? x_q : y_q;
	assign pos_sum = POS_W'(pos_old) + POS_W'(pos_inc);

	always_comb begin
		if (pos_sum > POS_MAX) begin
			pos_sat = 32'sh7FFF_FFFF;
		end else if (pos_sum < POS_MIN) begin
			pos_sat = -32'sh8000_0000;
		end else begin
			pos_sat = 32'(pos_sum);
		end
	end

	// control, registers and pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_CENTRE;
			mph_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			mpt_q <= MPT_RESET;
			iwb_q <= IWB_RESET;
			x_q <= '0;
			y_q <= '0;
			heading_q <= '0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			mph_q <= mph_d;
			if (start) begin
				cnt_q <= '0;
			end else if (cordic_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_METERS_PER_TICK:    mpt_q <= cfg_data;
					REG_INVERSE_WHEEL_BASE: iwb_q <= cfg_data;
					default: ;
				endcase
			end
			if (mul_use) begin
				unique case (op_q)
					OP_TURN_LO: heading_q <= heading_q + turn_q + prod_q[63:32];
					OP_X_LO:    x_q <= pos_sat;
					OP_Y_LO:    y_q <= pos_sat;
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			tsum_q <= (TICK_WIDTH+1)'(left_ticks) + (TICK_WIDTH+1)'(right_ticks);
			tdiff_q <= (TICK_WIDTH+1)'(right_ticks) - (TICK_WIDTH+1)'(left_ticks);
			quad_q <= fold_sum[31:30];
			z_q <= Z_W'($signed(fold_z));
			cx_q <= CORDIC_GAIN;
			cy_q <= '0;
		end else if (cordic_step) begin
			if (!z_q[Z_W-1]) begin
				cx_q <= cx_q - sh_y;
				cy_q <= cy_q + sh_x;
				z_q <= z_q - rot_atan;
			end else begin
				cx_q <= cx_q + sh_y;
				cy_q <= cy_q - sh_x;
				z_q <= z_q + rot_atan;
			end
		end
		if (mul_fire) begin
			prod_q <= mul_p;
		end
		if (mul_use) begin
			unique case (op_q)
				OP_CENTRE:  centre_q <= prod_q[CENTRE_W+8:9];
				OP_RATE:    rate_q <= prod_q[63:0];
				OP_STEP_HI: step_q <= {prod_q[47:0], 16'd0};
				OP_STEP_LO: step_q <= step_q + {16'd0, prod_q[63:16]};
				OP_TURN_HI: turn_q <= prod_q[31:0];
				OP_X_HI, OP_Y_HI: acc_q <= {prod_q[ACC_W-33:0], 32'd0};
				default: ;
			endcase
		end
		if (finish) begin
			out_x_q <= x_q;
			out_y_q <= pos_sat;
			out_h_q <= heading_q;
		end
	end

	`DDO_ASSERT_NEXT(a_accept_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, state_q == ST_BUSY, "accepted request did not start work")
	`DDO_ASSERT_NEXT(a_idle_pose_stable, clk, arst_n, state_q == ST_IDLE, $stable(heading_q) && $stable(x_q) && $stable(y_q), "pose changed while idle")
	`DDO_ASSERT_NOW(a_result_after_cordic, clk, arst_n, $rose(m_axis_tvalid), state_q == ST_IDLE && cnt_q == CNT_W'(CORDIC_STEPS), "result shown before rotation finished")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the differential drive odometry block
// ----------------------------------------------------------------------------
// Tick requests go in on the slave stream and poses come back on the master
// stream. Each accepted request is run through a local pose predictor:
// wheel travel, CORDIC cosine and sine of the old heading, saturating x and
// y, wrapping heading. Each returned pose is compared field by field with
// the oldest prediction. A directed table comes first, then random phases.
// Each phase reprograms the two registers while the block is idle. Both
// streams stall at random save in one phase; the sink once holds off long.

module testbench;

	localparam int TICKS_W = 16;
	localparam int ROTATIONS = 24;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int PHASES = 6;
	localparam int QUIET_LIMIT = 5000;

	localparam logic [7:0] REG_UNUSED_LOW = 8'd2;
	localparam logic [7:0] REG_UNUSED_TOP = 8'hFF;

	localparam longint ROTATOR_GAIN = 64'sd652032874;
	localparam longint TRIG_ONE = 64'sd1073741824;
	localparam logic [63:0] BAM_PER_RADIAN = 64'd683565276;

	// arctangent of 2^-k, binary angle units
	localparam longint ARCTAN_BAM [32] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
		64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
		64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
		64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        heading;
	} pose_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [7:0]          idx;
		logic [31:0]         data;
		logic signed [15:0]  left;
		logic signed [15:0]  right;
		logic                typed;
		pose_t               want;
	} row_t;

	typedef enum logic [2:0] {
		SET_TYPICAL,
		SET_RANDOM,
		SET_ZERO,
		SET_MAX,
		SET_MIN
	} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [31:0] mpt_reg = ddo_pkg::MPT_RESET;
	logic [31:0] iwb_reg = ddo_pkg::IWB_RESET;
	pose_t odo = '0;

	pose_t pose_q [$];
	int errors = 0;
	int src_idle_pct = 35;
	int sink_idle_pct = 35;
	int quiet = 0;
	row_t plan [31];

	diff_drive_odometry #(
		.TICK_WIDTH(TICKS_W),
		.CORDIC_STEPS(ROTATIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// cosine and sine of a binary angle in Q2.30
	function automatic void heading_trig(input logic [31:0] angle,
			output longint cos_q30, output longint sin_q30);
		logic [31:0] quad;
		logic [31:0] folded;
		longint z, vx, vy, nx, ny;
		int k;
		quad = (angle + 32'h40000000) >> 30;
		folded = angle - (quad << 30);
		z = longint'($signed(folded));
		vx = ROTATOR_GAIN;
		vy = 0;
		for (int i = 0; i < ROTATIONS; i++) begin
			k = i % 32;
			if (z >= 0) begin
				nx = vx - (vy >>> k);
				ny = vy + (vx >>> k);
				z = z - ARCTAN_BAM[k];
			end else begin
				nx = vx + (vy >>> k);
				ny = vy - (vx >>> k);
				z = z + ARCTAN_BAM[k];
			end
			vx = nx;
			vy = ny;
		end
		vx = vx > TRIG_ONE ? TRIG_ONE : (vx < -TRIG_ONE ? -TRIG_ONE : vx);
		vy = vy > TRIG_ONE ? TRIG_ONE : (vy < -TRIG_ONE ? -TRIG_ONE : vy);
		case (quad[1:0])
			2'd0: begin
				cos_q30 = vx;
				sin_q30 = vy;
			end
			2'd1: begin
				cos_q30 = -vy;
				sin_q30 = vx;
			end
			2'd2: begin
				cos_q30 = -vx;
				sin_q30 = -vy;
			end
			default: begin
				cos_q30 = vy;
				sin_q30 = -vx;
			end
		endcase
	endfunction

	// floor(travel * trig / 2^30)
	function automatic longint scale_q30(input longint travel, input longint trig);
		logic signed [127:0] a, b, p;
		a = travel;
		b = trig;
		p = a * b;
		return longint'(p >>> 30);
	endfunction

	function automatic logic signed [31:0] saturate32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic pose_t advance_pose(input logic signed [15:0] left,
			input logic signed [15:0] right);
		longint tsum, tdiff, centre, c, s;
		logic [63:0] rate, rh, rl, step, turn, diff64;
		tsum = longint'(left) + longint'(right);
		tdiff = longint'(right) - longint'(left);
		centre = (tsum * longint'({32'b0, mpt_reg})) >>> 9;
		heading_trig(odo.heading, c, s);
		odo.x = saturate32(longint'(odo.x) + scale_q30(centre, c));
		odo.y = saturate32(longint'(odo.y) + scale_q30(centre, s));
		rate = {32'b0, mpt_reg} * {32'b0, iwb_reg};
		rh = {32'b0, rate[63:32]};
		rl = {32'b0, rate[31:0]};
		step = ((rh * BAM_PER_RADIAN) << 16) + ((rl * BAM_PER_RADIAN) >> 16);
		diff64 = tdiff;
		turn = diff64 * step;
		odo.heading = odo.heading + turn[63:32];
		return odo;
	endfunction

	function automatic logic [31:0] random_ticks();
		int pick;
		logic [15:0] a, b;
		logic [15:0] corners [5];
		corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
		pick = $urandom_range(99);
		if (pick < 55) begin
			a = 16'($signed($urandom_range(600)) - 300);
			b = 16'($signed($urandom_range(600)) - 300);
		end else if (pick < 80) begin
			a = 16'($urandom);
			b = 16'($urandom);
		end else if (pick < 90) begin
			a = corners[$urandom_range(4)];
			b = corners[$urandom_range(4)];
		end else begin
			a = 16'($signed($urandom_range(2000)) - 1000);
			b = a;
		end
		return {b, a};
	endfunction

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pose_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [31:0] data,
			input logic hold);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == ddo_pkg::REG_METERS_PER_TICK)
			mpt_reg = data;
		else if (idx == ddo_pkg::REG_INVERSE_WHEEL_BASE)
			iwb_reg = data;
		if (!hold)
			cfg_valid <= 1'b0;
	endtask

	task automatic send_ticks(input logic signed [15:0] left,
			input logic signed [15:0] right, input logic typed, input pose_t want);
		pose_t next;
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(40, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {right, left};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		next = advance_pose(left, right);
		pose_q.push_back(typed ? want : next);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d (0x%08h) actual %0d (0x%08h)",
				name, $signed(want), want, $signed(got), got);
			errors++;
		end
	endtask

	// pose sink
	initial begin
		pose_t want;
		int taken;
		int holdoff;
		taken = 0;
		holdoff = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pose_q.size() == 0) begin
					$error("pose returned with no request outstanding");
					errors++;
				end else begin
					want = pose_q.pop_front();
					check_field("pose_x", want.x, m_axis_tdata[31:0]);
					check_field("pose_y", want.y, m_axis_tdata[63:32]);
					check_field("pose_heading", want.heading, m_axis_tdata[95:64]);
				end
				taken++;
				if (taken == 300)
					holdoff = 400;
			end
			if (holdoff > 0) begin
				holdoff--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		setting_t mode;
		logic [31:0] mpt_val, iwb_val, ticks;
		logic mpt_first;
		plan = '{
			'{ROW_ITEM, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b1, '0},
			'{ROW_CFG, ddo_pkg::REG_METERS_PER_TICK, 32'd0, 16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_CFG, REG_UNUSED_LOW, 32'hFFFFFFFF, 16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_CFG, REG_UNUSED_TOP, 32'hFFFFFFFF, 16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh7FFF, 16'sh8000, 1'b1, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh8000, 16'sh7FFF, 1'b1, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 1'b1, '0},
			'{ROW_CFG, ddo_pkg::REG_METERS_PER_TICK, ddo_pkg::MPT_RESET,
				16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_CFG, ddo_pkg::REG_INVERSE_WHEEL_BASE, 32'd0, 16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh7FFF, 16'sh8000, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sd100, 16'sd100, 1'b0, '0},
			'{ROW_CFG, ddo_pkg::REG_INVERSE_WHEEL_BASE, ddo_pkg::IWB_RESET,
				16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh7FFF, 16'sh8000, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh8000, 16'sh7FFF, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sd1, -16'sd1, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, -16'sd1, 16'sd0, 1'b0, '0},
			'{ROW_CFG, ddo_pkg::REG_METERS_PER_TICK, 32'hFFFFFFFF, 16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_CFG, ddo_pkg::REG_INVERSE_WHEEL_BASE, 32'hFFFFFFFF,
				16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh8000, 16'sh8000, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sd123, -16'sd4567, 1'b0, '0},
			'{ROW_CFG, ddo_pkg::REG_METERS_PER_TICK, 32'd1, 16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_CFG, ddo_pkg::REG_INVERSE_WHEEL_BASE, 32'd1, 16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, 16'sh7FFF, 16'sh8000, 1'b0, '0},
			'{ROW_ITEM, 8'd0, 32'd0, -16'sd5, 16'sd7, 1'b0, '0},
			'{ROW_CFG, ddo_pkg::REG_METERS_PER_TICK, ddo_pkg::MPT_RESET,
				16'sd0, 16'sd0, 1'b0, '0},
			'{ROW_CFG, ddo_pkg::REG_INVERSE_WHEEL_BASE, ddo_pkg::IWB_RESET,
				16'sd0, 16'sd0, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int n = 0; n < $size(plan); n++) begin
			if (plan[n].kind == ROW_CFG) begin
				if (n == 0 || plan[n-1].kind != ROW_CFG)
					settle();
				write_reg(plan[n].idx, plan[n].data,
					n + 1 < $size(plan) && plan[n+1].kind == ROW_CFG);
			end else begin
				send_ticks(plan[n].left, plan[n].right, plan[n].typed, plan[n].want);
			end
		end

		// random phases, registers reprogrammed while idle
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			src_idle_pct = (ph == 2) ? 0 : 35;
			sink_idle_pct = (ph == 2) ? 0 : 35;
			mode = (ph == 0) ? SET_TYPICAL : setting_t'($urandom_range(4));
			case (mode)
				SET_TYPICAL: begin
					mpt_val = $urandom_range(200000, 1000);
					iwb_val = $urandom_range(20 << 24, 1 << 24);
				end
				SET_RANDOM: begin
					mpt_val = $urandom;
					iwb_val = $urandom;
				end
				SET_ZERO: begin
					mpt_val = $urandom_range(1) ? 32'd0 : $urandom_range(50000, 1000);
					iwb_val = (mpt_val != 0) ? 32'd0 : $urandom;
				end
				SET_MAX: begin
					mpt_val = 32'hFFFFFFFF;
					iwb_val = 32'hFFFFFFFF;
				end
				default: begin
					mpt_val = 32'd1;
					iwb_val = 32'd1;
				end
			endcase
			if ($urandom_range(1))
				write_reg(8'($urandom_range(255, 2)), $urandom, 1'b1);
			mpt_first = $urandom_range(1);
			if (mpt_first) begin
				write_reg(ddo_pkg::REG_METERS_PER_TICK, mpt_val, 1'b1);
				write_reg(ddo_pkg::REG_INVERSE_WHEEL_BASE, iwb_val, 1'b0);
			end else begin
				write_reg(ddo_pkg::REG_INVERSE_WHEEL_BASE, iwb_val, 1'b1);
				write_reg(ddo_pkg::REG_METERS_PER_TICK, mpt_val, 1'b0);
			end
			repeat (ITEMS_PER_PHASE) begin
				ticks = random_ticks();
				send_ticks(ticks[15:0], ticks[31:16], 1'b0, '0);
			end
		end

		settle();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/ddo_pkg.sv
sv/diff_drive_odometry.sv
sim/testbench.sv
